// ===== rtl/i2c_eeprom_byte_master_assert.svh =====
// Assertion macros for the EEPROM byte master, empty in synthesis.
`ifndef I2C_EEPROM_BYTE_MASTER_ASSERT_SVH
`define I2C_EEPROM_BYTE_MASTER_ASSERT_SVH

`ifndef SYNTHESIS
// Property checked at every clock edge outside reset.
`define EBM_ASSERT(label, prop) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error("i2c_eeprom_byte_master: check failed");
// Antecedent in one cycle implies consequent in the next.
`define EBM_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("i2c_eeprom_byte_master: sequencing check failed");
`else
`define EBM_ASSERT(label, prop)
`define EBM_ASSERT_NEXT(label, ante, cons)
`endif

`endif

// ===== rtl/i2c_ebm_pkg.sv =====
// Shared types, codes and sequence tables of the EEPROM byte master.
package i2c_ebm_pkg;

	localparam int DevAddrW = 7;
	localparam int PhaseW   = 4;
	localparam int StepW    = 6;

	localparam logic [DevAddrW-1:0] DevAddrReset = 7'd80;

	// Phase codes. Phases 6 to 11 differ between write and read.
	localparam logic [PhaseW-1:0] PH_IDLE  = 4'd0;
	localparam logic [PhaseW-1:0] PH_START = 4'd1;
	localparam logic [PhaseW-1:0] PH_DEVW  = 4'd2;
	localparam logic [PhaseW-1:0] PH_ACK0  = 4'd3;
	localparam logic [PhaseW-1:0] PH_WADDR = 4'd4;
	localparam logic [PhaseW-1:0] PH_ACK1  = 4'd5;
	localparam logic [PhaseW-1:0] PH_SEG6  = 4'd6;
	localparam logic [PhaseW-1:0] PH_SEG7  = 4'd7;
	localparam logic [PhaseW-1:0] PH_SEG8  = 4'd8;
	localparam logic [PhaseW-1:0] PH_SEG9  = 4'd9;
	localparam logic [PhaseW-1:0] PH_SEG10 = 4'd10;
	localparam logic [PhaseW-1:0] PH_SEG11 = 4'd11;

	// Segment kinds.
	localparam logic [2:0] K_NONE  = 3'd0;
	localparam logic [2:0] K_START = 3'd1;
	localparam logic [2:0] K_SEND  = 3'd2;
	localparam logic [2:0] K_ACK   = 3'd3;
	localparam logic [2:0] K_RECV  = 3'd4;
	localparam logic [2:0] K_MACK  = 3'd5;
	localparam logic [2:0] K_STOP  = 3'd6;

	localparam logic MODE_WRITE = 1'b0;
	localparam logic MODE_READ  = 1'b1;

	localparam logic [StepW-1:0] RecvLastStep = 6'd24;

	typedef struct packed {
		logic [PhaseW-1:0] phase;
		logic [StepW-1:0]  step;
		logic [1:0]        rsub;    // position inside a receive bit
		logic [7:0]        shift;
		logic [7:0]        rbyte;
		logic              mode;
		logic [7:0]        addr;
		logic [7:0]        data;
		logic              nack;
		logic              scl;
		logic              sda;
	} ebm_state_t;

	typedef struct packed {
		logic       start_req;
		logic       mode;
		logic [7:0] word_address;
		logic [7:0] write_data;
		logic       sda_in;
	} ebm_beat_t;

	typedef struct packed {
		logic       scl;
		logic       sda_out;
		logic       busy_res;
		logic       done_res;
		logic [7:0] read_data;
		logic       nack_seen;
	} ebm_result_t;

	function automatic logic [2:0] seg_kind(input logic mode, input logic [PhaseW-1:0] phase);
		logic [2:0] k;
		k = K_NONE;
		unique case (phase)
			PH_START, PH_SEG6: k = (phase == PH_START || mode == MODE_READ) ? K_START : K_SEND;
			PH_DEVW, PH_WADDR: k = K_SEND;
			PH_ACK0, PH_ACK1:  k = K_ACK;
			PH_SEG7:  k = (mode == MODE_READ) ? K_SEND : K_ACK;
			PH_SEG8:  k = (mode == MODE_READ) ? K_ACK : K_STOP;
			PH_SEG9:  k = (mode == MODE_READ) ? K_RECV : K_NONE;
			PH_SEG10: k = (mode == MODE_READ) ? K_MACK : K_NONE;
			PH_SEG11: k = (mode == MODE_READ) ? K_STOP : K_NONE;
			default:  k = K_NONE;
		endcase
		return k;
	endfunction

	function automatic logic [StepW-1:0] seg_len(input logic [2:0] kind);
		logic [StepW-1:0] n;
		unique case (kind)
			K_START, K_ACK, K_MACK: n = 6'd4;
			K_SEND:  n = 6'd32;
			K_RECV:  n = 6'd25;
			K_STOP:  n = 6'd3;
			default: n = 6'd1;
		endcase
		return n;
	endfunction

endpackage

// ===== rtl/i2c_eeprom_byte_master.sv =====
// Top level of the I2C master for EEPROM byte write and random byte read.
//
// Each input beat on s_* is one tick of the bit-banged bus sequence. A beat
// carrying start_req while idle latches mode, word address and write data;
// that tick moves no pin. Following beats step through start, device
// address, word address, then data and stop (write), or repeated start,
// device address with read bit, eight received bits, master ack and stop
// (read). Every beat returns exactly one result beat on m_* holding the pin
// levels after the tick, busy, done, the last read byte and a sticky nack.
// Throughput: one beat per cycle while the result is taken, set by the single
// state register that the step logic updates on each taken beat. The result is
// valid in the cycle after the input beat is taken (one result register).
// When m_tready is low the result register holds its beat and s_tready
// drops, so no tick is taken until the held result is taken; s_tready
// returns in the same cycle m_tready rises.
// cfg_* writes the 7-bit device address; it is always ready and should be
// written only while no transfer is running.
// Reset (arst_n low) clears the sequencer to idle with SCL and SDA released
// high, the device address to 80, and empties the result register.

`include "i2c_eeprom_byte_master_assert.svh"

module i2c_eeprom_byte_master (
	input  logic        clk,
	input  logic        arst_n,
	// tick beats
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,   // start_req, mode, word_address[7:0],
	                               // write_data[7:0], sda_in, zero pad
	// result beats
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // scl, sda_out, busy_res, done_res,
	                               // read_data[7:0], nack_seen, zero pad
	// device address register
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [i2c_ebm_pkg::DevAddrW-1:0] cfg_data
);
	import i2c_ebm_pkg::*;

	localparam ebm_state_t StateReset = '{
		phase: PH_IDLE,
		step:  6'd0,
		rsub:  2'd0,
		shift: 8'd0,
		rbyte: 8'd0,
		mode:  MODE_WRITE,
		addr:  8'd0,
		data:  8'd0,
		nack:  1'b0,
		scl:   1'b1,
		sda:   1'b1
	};

	ebm_state_t           state_q;
	ebm_state_t           state_nxt;
	ebm_result_t          res_nxt;
	ebm_result_t          res_q;
	ebm_beat_t            beat;
	logic                 m_tvalid_q;
	logic [DevAddrW-1:0]  dev_addr_q;
	logic                 s_acc;

	assign beat.start_req    = s_tdata[0];
	assign beat.mode         = s_tdata[1];
	assign beat.word_address = s_tdata[9:2];
	assign beat.write_data   = s_tdata[17:10];
	assign beat.sda_in       = s_tdata[18];

	// The result register frees itself in the cycle its beat is taken.
	assign s_tready  = !m_tvalid_q || m_tready;
	assign s_acc     = s_tvalid && s_tready;
	assign cfg_ready = 1'b1;

	i2c_ebm_step u_step (
		.cur      (state_q),
		.beat     (beat),
		.dev_addr (dev_addr_q),
		.nxt      (state_nxt),
		.res      (res_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dev_addr_q <= DevAddrReset;
		end else if (cfg_valid && cfg_ready) begin
			dev_addr_q <= cfg_data;
		end
	end

	// Sequencer state: idle phase, lines released, everything else zero.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= StateReset;
		end else if (s_acc) begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (s_acc) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	// Result payload, no reset needed.
	always_ff @(posedge clk) begin
		if (s_acc) res_q <= res_nxt;
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {3'b000, res_q.nack_seen, res_q.read_data, res_q.done_res,
	                   res_q.busy_res, res_q.sda_out, res_q.scl};

	// A stop completes only as the sequencer returns to idle.
	`EBM_ASSERT(a_done_not_busy, !(m_tvalid_q && res_q.done_res && res_q.busy_res))
	// A request taken while idle always enters the start phase.
	`EBM_ASSERT_NEXT(a_start_enters, s_acc && s_tdata[0] && state_q.phase == PH_IDLE,
		state_q.phase == PH_START)
	// With the result register empty s_tready is always high.
	`EBM_ASSERT(a_ready_when_empty, m_tvalid_q || s_tready)
	// The result beat mirrors the lines held in the sequencer state.
	`EBM_ASSERT(a_pins_match, !m_tvalid_q ||
		(res_q.scl == state_q.scl && res_q.sda_out == state_q.sda))

endmodule

// ===== rtl/i2c_ebm_step.sv =====
// Next-state and result logic for one tick of the EEPROM byte master.
module i2c_ebm_step (
	input  i2c_ebm_pkg::ebm_state_t        cur,
	input  i2c_ebm_pkg::ebm_beat_t         beat,
	input  logic [i2c_ebm_pkg::DevAddrW-1:0] dev_addr,
	output i2c_ebm_pkg::ebm_state_t        nxt,
	output i2c_ebm_pkg::ebm_result_t       res
);
	import i2c_ebm_pkg::*;

	logic [2:0]       kind;
	logic [1:0]       sub;
	logic [StepW-1:0] step_inc;
	logic [7:0]       send_byte;
	logic             done;

	assign kind     = seg_kind(cur.mode, cur.phase);
	assign sub      = cur.step[1:0];
	assign step_inc = cur.step + 6'd1;

	// Byte loaded at the first step of a send segment.
	always_comb begin
		if (cur.step != '0) begin
			send_byte = cur.shift;
		end else if (cur.phase == PH_DEVW) begin
			send_byte = {dev_addr, MODE_WRITE};
		end else if (cur.phase == PH_WADDR) begin
			send_byte = cur.addr;
		end else if (cur.mode == MODE_WRITE) begin
			send_byte = cur.data;
		end else begin
			send_byte = {dev_addr, MODE_READ};
		end
	end

	always_comb begin
		nxt  = cur;
		done = 1'b0;
		if (cur.phase == PH_IDLE) begin
			if (beat.start_req) begin
				nxt.mode  = beat.mode;
				nxt.addr  = beat.word_address;
				nxt.data  = beat.write_data;
				nxt.nack  = 1'b0;
				nxt.phase = PH_START;
				nxt.step  = '0;
			end
		end else begin
			unique case (kind)
				K_START: begin
					unique case (sub)
						2'd0:    nxt.sda = 1'b1;
						2'd1:    nxt.scl = 1'b1;
						2'd2:    nxt.sda = 1'b0;
						default: nxt.scl = 1'b0;
					endcase
				end
				K_SEND: begin
					nxt.shift = send_byte;
					unique case (sub)
						2'd0: nxt.scl = 1'b0;
						2'd1: begin
							nxt.sda   = send_byte[7];
							nxt.shift = {send_byte[6:0], 1'b0};
						end
						2'd2:    nxt.scl = 1'b1;
						default: nxt.scl = 1'b0;
					endcase
				end
				K_ACK: begin
					unique case (sub)
						2'd0: nxt.sda = 1'b1;
						2'd1: nxt.scl = 1'b0;
						2'd2: begin
							nxt.scl = 1'b1;
							if (beat.sda_in) nxt.nack = 1'b1;
						end
						default: nxt.scl = 1'b0;
					endcase
				end
				K_RECV: begin
					if (cur.step == '0) begin
						nxt.sda   = 1'b1;
						nxt.shift = '0;
						nxt.rsub  = 2'd0;
					end else begin
						unique case (cur.rsub)
							2'd0: begin
								nxt.scl  = 1'b0;
								nxt.rsub = 2'd1;
							end
							2'd1: begin
								nxt.scl   = 1'b1;
								nxt.shift = {cur.shift[6:0], beat.sda_in};
								nxt.rsub  = 2'd2;
							end
							default: begin
								nxt.scl  = 1'b0;
								nxt.rsub = 2'd0;
								if (cur.step == RecvLastStep) nxt.rbyte = cur.shift;
							end
						endcase
					end
				end
				K_MACK: begin
					unique case (sub)
						2'd0:    nxt.scl = 1'b0;
						2'd1:    nxt.sda = 1'b0;
						2'd2:    nxt.scl = 1'b1;
						default: nxt.scl = 1'b0;
					endcase
				end
				K_STOP: begin
					if (cur.step == 6'd0) begin
						nxt.sda = 1'b0;
					end else if (cur.step == 6'd1) begin
						nxt.scl = 1'b1;
					end else begin
						nxt.sda = 1'b1;
						done    = 1'b1;
					end
				end
				default: ;
			endcase

			if (kind == K_NONE) begin
				nxt.phase = PH_IDLE;
				nxt.step  = '0;
			end else if (step_inc >= seg_len(kind)) begin
				nxt.step  = '0;
				nxt.phase = (kind == K_STOP) ? PH_IDLE : cur.phase + 4'd1;
			end else begin
				nxt.step = step_inc;
			end
		end
	end

	assign res.scl       = nxt.scl;
	assign res.sda_out   = nxt.sda;
	assign res.busy_res  = (nxt.phase != PH_IDLE);
	assign res.done_res  = done;
	assign res.read_data = nxt.rbyte;
	assign res.nack_seen = nxt.nack;

endmodule
